FILE: hw/rtl/dpb_pkg.sv
// Shared types and constants for the decoded picture buffer bumping block.
`default_nettype none
package dpb_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam int TWO_REF_CAP = 2;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_FLUSH = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic EV_EMIT = 1'b0;
    localparam logic EV_DONE = 1'b1;

    localparam logic ST_OK = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [4:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_RD_IDX,
        CMD_RD_HELD,
        CMD_RD_ZERO,
        CMD_CAP0_RD1,
        CMD_IDX_INC,
        CMD_IDX_CLR,
        CMD_PG_DROP,
        CMD_WR_MOVE,
        CMD_BUMP_CHK,
        CMD_BUMP_EMIT,
        CMD_SET_FAIL,
        CMD_EMIT_NEW,
        CMD_STORE,
        CMD_OLD_CHK,
        CMD_CLEAR_HELD,
        CMD_REL_CHK,
        CMD_TWO_SEL,
        CMD_TWO_EMIT,
        CMD_STORE_SEL,
        CMD_OUT_EMIT,
        CMD_OUT_DONE
    } dpb_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic two_mode;
        logic item_ref;
        logic item_skip;
        logic item_outm;
        logic idx_lt_held;
        logic idx_is_last;
        logic rd_drop;
        logic full;
        logic older;
        logic found;
        logic best_ref;
        logic best_is_last;
        logic best_out;
        logic held_ge2;
        logic q_empty;
        logic out_free;
    } dpb_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/decoded_picture_buffer_bump.sv
// Top level of the decoded picture buffer with bumping output.
//
// Holds up to the configured number of pictures in a slot RAM with one read
// and one write port and handles one command transaction at a time (add,
// flush, release). Every slot scan reads one slot at a time through the
// registered RAM read, and each compaction move adds a read and a write. An
// add costs one purge pass plus one scan pass per bump; a flush costs one pass
// per emitted picture and a closing pass. Emitted pictures are queued and
// delivered after the step with the final fill count, followed by the done
// transaction.
// A new command is taken once the previous done transaction is in the output
// register. No clearing pass is needed after reset.
`default_nettype none
module decoded_picture_buffer_bump #(
    parameter int MAX_SLOTS = 16,
    parameter int ID_BITS = 16,
    parameter int ORDER_BITS = 32,
    localparam int CW = $clog2(MAX_SLOTS + 1),
    localparam int IN_W = ID_BITS + ORDER_BITS + 3,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = ID_BITS + ORDER_BITS + 1 + CW,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [dpb_pkg::CAP_W-1:0] cfg_wr_data,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // pic_id, order_count, is_reference, is_skipped, already_output
    input  wire logic [IN_TW-1:0]          s_tdata,
    // kind
    input  wire logic [1:0]                s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // out_id, out_order, status, fill_count
    output logic [OUT_TW-1:0]              m_tdata,
    // event_res
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import dpb_pkg::*;

    localparam int O_LO = ID_BITS;
    localparam int F_LO = ID_BITS + ORDER_BITS;

    dpb_cmd_t cmd;
    dpb_status_t status;
    logic out_ev, out_status, out_last;
    logic [ID_BITS-1:0] out_id;
    logic [ORDER_BITS-1:0] out_order;
    logic [CW-1:0] out_fill;

    dpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dpb_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .ID_BITS    (ID_BITS),
        .ORDER_BITS (ORDER_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_kind     (s_tuser),
        .in_id       (s_tdata[ID_BITS-1:0]),
        .in_order    (s_tdata[F_LO-1:O_LO]),
        .in_ref      (s_tdata[F_LO]),
        .in_skip     (s_tdata[F_LO+1]),
        .in_outm     (s_tdata[F_LO+2]),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_ev      (out_ev),
        .out_id      (out_id),
        .out_order   (out_order),
        .out_status  (out_status),
        .out_fill    (out_fill),
        .out_last    (out_last)
    );

    assign m_tdata = OUT_TW'({out_fill, out_status, out_order, out_id});
    assign m_tuser = out_ev;
    assign m_tlast = out_last;

    // the done transaction is the only one that closes a step
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == EV_DONE)))
        else $error("tlast does not match done transaction");

    // emit transactions never report a full buffer
    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_EMIT)) |-> (m_tdata[F_LO] == ST_OK))
        else $error("emit transaction carries nonzero status");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[F_LO+CW:F_LO+1] <= CW'(MAX_SLOTS)))
        else $error("fill count beyond slot count");

    // a command is taken only once the output register holds no emit
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tvalid) |-> (m_tuser == EV_DONE))
        else $error("command accepted with emits pending");
endmodule
`default_nettype wire

FILE: hw/rtl/dpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/dpb_ctrl.sv
// Sequencer for the picture buffer: issues at most one datapath command per cycle.
`default_nettype none
module dpb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      in_ready,
    input  wire dpb_pkg::dpb_status_t status,
    output dpb_pkg::dpb_cmd_t         cmd
);
    import dpb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_PG_RD, S_PG_CHK, S_MV_RD, S_MV_WR, S_ADD_CHK, S_STORE,
        S_OL_INIT, S_OL_RD, S_OL_CHK, S_OL_END, S_BM_INIT, S_BM_RD, S_BM_CHK, S_BM_END,
        S_FL_END, S_RL_RD, S_RL_CHK, S_T0, S_T1, S_T2, S_T3, S_T_NEW,
        S_DRN_RD, S_DRN_LD, S_DONE
    } state_t;

    state_t state_reg, state_next;
    state_t bm_ret_reg, bm_ret_next;
    state_t mv_ret_reg, mv_ret_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        bm_ret_next = bm_ret_reg;
        mv_ret_next = mv_ret_reg;
        cmd = CMD_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    KIND_ADD:     state_next = status.two_mode ? S_T0 : S_PG_RD;
                    KIND_FLUSH:
                    begin
                        bm_ret_next = S_BM_INIT;
                        state_next = S_BM_INIT;
                    end
                    KIND_RELEASE: state_next = S_RL_RD;
                    default:      state_next = S_DRN_RD;
                endcase
            end
            // drop entries that are output and unreferenced
            S_PG_RD:
            begin
                if (status.idx_lt_held)
                begin
                    cmd = CMD_RD_IDX;
                    state_next = S_PG_CHK;
                end
                else
                begin
                    state_next = S_ADD_CHK;
                end
            end
            S_PG_CHK:
            begin
                if (status.rd_drop)
                begin
                    cmd = CMD_PG_DROP;
                    if (status.idx_is_last)
                    begin
                        state_next = S_PG_RD;
                    end
                    else
                    begin
                        mv_ret_next = S_PG_RD;
                        state_next = S_MV_RD;
                    end
                end
                else
                begin
                    cmd = CMD_IDX_INC;
                    state_next = S_PG_RD;
                end
            end
            // last entry fills the gap
            S_MV_RD:
            begin
                cmd = CMD_RD_HELD;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd = CMD_WR_MOVE;
                state_next = mv_ret_reg;
            end
            S_ADD_CHK:
            begin
                if (!status.item_ref && status.item_skip)
                begin
                    state_next = S_DRN_RD;
                end
                else if (!status.full)
                begin
                    state_next = S_STORE;
                end
                else if (status.item_ref)
                begin
                    bm_ret_next = S_ADD_CHK;
                    state_next = S_BM_INIT;
                end
                else if (status.item_outm)
                begin
                    cmd = CMD_EMIT_NEW;
                    state_next = S_DRN_RD;
                end
                else
                begin
                    state_next = S_OL_INIT;
                end
            end
            S_STORE:
            begin
                cmd = CMD_STORE;
                state_next = S_DRN_RD;
            end
            S_OL_INIT:
            begin
                cmd = CMD_IDX_CLR;
                state_next = S_OL_RD;
            end
            S_OL_RD:
            begin
                if (status.idx_lt_held)
                begin
                    cmd = CMD_RD_IDX;
                    state_next = S_OL_CHK;
                end
                else
                begin
                    state_next = S_OL_END;
                end
            end
            S_OL_CHK:
            begin
                cmd = CMD_OLD_CHK;
                state_next = S_OL_RD;
            end
            S_OL_END:
            begin
                if (status.older)
                begin
                    bm_ret_next = S_ADD_CHK;
                    state_next = S_BM_INIT;
                end
                else
                begin
                    cmd = CMD_EMIT_NEW;
                    state_next = S_DRN_RD;
                end
            end
            S_BM_INIT:
            begin
                cmd = CMD_IDX_CLR;
                state_next = S_BM_RD;
            end
            S_BM_RD:
            begin
                if (status.idx_lt_held)
                begin
                    cmd = CMD_RD_IDX;
                    state_next = S_BM_CHK;
                end
                else
                begin
                    state_next = S_BM_END;
                end
            end
            S_BM_CHK:
            begin
                cmd = CMD_BUMP_CHK;
                state_next = S_BM_RD;
            end
            S_BM_END:
            begin
                if (!status.found)
                begin
                    if (status.kind == KIND_FLUSH)
                    begin
                        state_next = S_FL_END;
                    end
                    else
                    begin
                        cmd = CMD_SET_FAIL;
                        state_next = S_DRN_RD;
                    end
                end
                else
                begin
                    cmd = CMD_BUMP_EMIT;
                    if (status.best_ref || status.best_is_last)
                    begin
                        state_next = bm_ret_reg;
                    end
                    else
                    begin
                        mv_ret_next = bm_ret_reg;
                        state_next = S_MV_RD;
                    end
                end
            end
            S_FL_END:
            begin
                cmd = CMD_CLEAR_HELD;
                state_next = S_DRN_RD;
            end
            S_RL_RD:
            begin
                if (status.idx_lt_held)
                begin
                    cmd = CMD_RD_IDX;
                    state_next = S_RL_CHK;
                end
                else
                begin
                    state_next = S_DRN_RD;
                end
            end
            S_RL_CHK:
            begin
                cmd = CMD_REL_CHK;
                state_next = S_RL_RD;
            end
            // two-reference replace mode
            S_T0:
            begin
                if (status.held_ge2)
                begin
                    cmd = CMD_RD_ZERO;
                    state_next = S_T1;
                end
                else
                begin
                    state_next = S_T_NEW;
                end
            end
            S_T1:
            begin
                cmd = CMD_CAP0_RD1;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd = CMD_TWO_SEL;
                state_next = S_T3;
            end
            S_T3:
            begin
                if (!status.best_out)
                begin
                    cmd = CMD_TWO_EMIT;
                end
                state_next = S_T_NEW;
            end
            S_T_NEW:
            begin
                if (!status.item_ref)
                begin
                    cmd = CMD_EMIT_NEW;
                end
                else if (!status.held_ge2)
                begin
                    cmd = CMD_STORE;
                end
                else
                begin
                    cmd = CMD_STORE_SEL;
                end
                state_next = S_DRN_RD;
            end
            // hand queued pictures to the output, then the done transaction
            S_DRN_RD:
            begin
                state_next = status.q_empty ? S_DONE : S_DRN_LD;
            end
            S_DRN_LD:
            begin
                if (status.out_free)
                begin
                    cmd = CMD_OUT_EMIT;
                    state_next = S_DRN_RD;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd = CMD_OUT_DONE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bm_ret_reg <= S_IDLE;
            mv_ret_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            bm_ret_reg <= bm_ret_next;
            mv_ret_reg <= mv_ret_next;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/dpb_datapath.sv
// Picture slot store, result queue and output register, driven by sequencer commands.
`default_nettype none
module dpb_datapath #(
    parameter int MAX_SLOTS = 16,
    parameter int ID_BITS = 16,
    parameter int ORDER_BITS = 32,
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [dpb_pkg::CAP_W-1:0] cfg_wr_data,
    input  wire logic [1:0]               in_kind,
    input  wire logic [ID_BITS-1:0]       in_id,
    input  wire logic [ORDER_BITS-1:0]    in_order,
    input  wire logic                     in_ref,
    input  wire logic                     in_skip,
    input  wire logic                     in_outm,
    input  wire dpb_pkg::dpb_cmd_t        cmd,
    output dpb_pkg::dpb_status_t          status,
    input  wire logic                     m_tready,
    output logic                          out_valid,
    output logic                          out_ev,
    output logic [ID_BITS-1:0]            out_id,
    output logic [ORDER_BITS-1:0]         out_order,
    output logic                          out_status,
    output logic [CW-1:0]                 out_fill,
    output logic                          out_last
);
    import dpb_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam int QD = MAX_SLOTS + 1;
    localparam int QW = $clog2(QD);
    localparam int SLW = ID_BITS + ORDER_BITS + 2;
    localparam int QEW = ID_BITS + ORDER_BITS;

    typedef struct packed {
        logic                  ref_m;
        logic                  out_m;
        logic [ORDER_BITS-1:0] order;
        logic [ID_BITS-1:0]    id;
    } slot_t;

    typedef struct packed {
        logic [ORDER_BITS-1:0] order;
        logic [ID_BITS-1:0]    id;
    } qent_t;

    // control registers
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [QW-1:0] wp_reg, wp_next;
    logic [QW-1:0] rp_reg, rp_next;
    logic found_reg, found_next;
    logic older_reg, older_next;
    logic st_reg, st_next;
    logic out_valid_reg, out_valid_next;

    // payload registers
    logic [1:0] kind_reg, kind_next;
    slot_t item_reg, item_next;
    logic skip_reg, skip_next;
    slot_t o0_reg, o0_next;
    slot_t best_reg, best_next;
    logic [SW-1:0] best_idx_reg, best_idx_next;
    logic [SW-1:0] mv_dst_reg, mv_dst_next;
    logic ev_reg, ev_next;
    qent_t oq_reg, oq_next;
    logic ost_reg, ost_next;
    logic [CW-1:0] ofill_reg, ofill_next;

    logic slot_we;
    logic [SW-1:0] slot_waddr, slot_raddr;
    slot_t slot_wr, slot_rd;
    logic [SLW-1:0] slot_rdata;
    logic q_we;
    qent_t q_wr, q_rd;
    logic [QEW-1:0] q_rdata;

    logic [EW-1:0] cap_ext, eff_cap;
    logic out_free;

    assign slot_rd = slot_t'(slot_rdata);
    assign q_rd = qent_t'(q_rdata);

    dpb_ram #(.WIDTH(SLW), .DEPTH(MAX_SLOTS)) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wr),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    dpb_ram #(.WIDTH(QEW), .DEPTH(QD)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (wp_reg),
        .wdata (q_wr),
        .raddr (rp_reg),
        .rdata (q_rdata)
    );

    // capacity clamp: zero acts as one, above the slot count acts as the slot count
    assign cap_ext = EW'(cap_reg);
    assign eff_cap = (cap_reg == '0) ? EW'(1) :
                     (cap_ext > EW'(MAX_SLOTS)) ? EW'(MAX_SLOTS) : cap_ext;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        status.kind = kind_reg;
        status.two_mode = (eff_cap == EW'(TWO_REF_CAP));
        status.item_ref = item_reg.ref_m;
        status.item_skip = skip_reg;
        status.item_outm = item_reg.out_m;
        status.idx_lt_held = (idx_reg < held_reg);
        status.idx_is_last = (CW'(idx_reg + CW'(1)) == held_reg);
        status.rd_drop = slot_rd.out_m && !slot_rd.ref_m;
        status.full = (EW'(held_reg) >= eff_cap);
        status.older = older_reg;
        status.found = found_reg;
        status.best_ref = best_reg.ref_m;
        status.best_is_last = (CW'(CW'(best_idx_reg) + CW'(1)) == held_reg);
        status.best_out = best_reg.out_m;
        status.held_ge2 = (held_reg >= CW'(TWO_REF_CAP));
        status.q_empty = (rp_reg == wp_reg);
        status.out_free = out_free;
    end

    always_comb
    begin
        cap_next = cfg_wr_en ? cfg_wr_data : cap_reg;
        held_next = held_reg;
        idx_next = idx_reg;
        wp_next = wp_reg;
        rp_next = rp_reg;
        found_next = found_reg;
        older_next = older_reg;
        st_next = st_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        kind_next = kind_reg;
        item_next = item_reg;
        skip_next = skip_reg;
        o0_next = o0_reg;
        best_next = best_reg;
        best_idx_next = best_idx_reg;
        mv_dst_next = mv_dst_reg;
        ev_next = ev_reg;
        oq_next = oq_reg;
        ost_next = ost_reg;
        ofill_next = ofill_reg;
        slot_we = 1'b0;
        slot_waddr = idx_reg[SW-1:0];
        slot_raddr = idx_reg[SW-1:0];
        slot_wr = slot_rd;
        q_we = 1'b0;
        q_wr = '{order: item_reg.order, id: item_reg.id};
        case (cmd)
            CMD_LOAD:
            begin
                kind_next = in_kind;
                item_next = '{ref_m: in_ref, out_m: in_outm, order: in_order, id: in_id};
                skip_next = in_skip;
                st_next = ST_OK;
                wp_next = '0;
                rp_next = '0;
                idx_next = '0;
                found_next = 1'b0;
                older_next = 1'b0;
            end
            CMD_RD_IDX:
            begin
                slot_raddr = idx_reg[SW-1:0];
            end
            CMD_RD_HELD:
            begin
                slot_raddr = held_reg[SW-1:0];
            end
            CMD_RD_ZERO:
            begin
                slot_raddr = '0;
            end
            CMD_CAP0_RD1:
            begin
                o0_next = slot_rd;
                slot_raddr = SW'(1);
            end
            CMD_IDX_INC:
            begin
                idx_next = idx_reg + CW'(1);
            end
            CMD_IDX_CLR:
            begin
                idx_next = '0;
                found_next = 1'b0;
                older_next = 1'b0;
            end
            CMD_PG_DROP:
            begin
                held_next = held_reg - CW'(1);
                mv_dst_next = idx_reg[SW-1:0];
            end
            CMD_WR_MOVE:
            begin
                slot_we = 1'b1;
                slot_waddr = mv_dst_reg;
                slot_wr = slot_rd;
            end
            CMD_BUMP_CHK:
            begin
                // strict compare keeps the lowest slot on ties
                if (!slot_rd.out_m &&
                    (!found_reg || ($signed(slot_rd.order) < $signed(best_reg.order))))
                begin
                    found_next = 1'b1;
                    best_next = slot_rd;
                    best_idx_next = idx_reg[SW-1:0];
                end
                idx_next = idx_reg + CW'(1);
            end
            CMD_BUMP_EMIT:
            begin
                q_we = 1'b1;
                q_wr = '{order: best_reg.order, id: best_reg.id};
                wp_next = wp_reg + QW'(1);
                if (best_reg.ref_m)
                begin
                    slot_we = 1'b1;
                    slot_waddr = best_idx_reg;
                    slot_wr = best_reg;
                    slot_wr.out_m = 1'b1;
                end
                else
                begin
                    held_next = held_reg - CW'(1);
                    mv_dst_next = best_idx_reg;
                end
            end
            CMD_SET_FAIL:
            begin
                st_next = ST_FULL;
            end
            CMD_EMIT_NEW:
            begin
                q_we = 1'b1;
                wp_next = wp_reg + QW'(1);
            end
            CMD_STORE:
            begin
                slot_we = 1'b1;
                slot_waddr = held_reg[SW-1:0];
                slot_wr = item_reg;
                held_next = held_reg + CW'(1);
            end
            CMD_OLD_CHK:
            begin
                if ($signed(slot_rd.order) < $signed(item_reg.order))
                begin
                    older_next = 1'b1;
                end
                idx_next = idx_reg + CW'(1);
            end
            CMD_CLEAR_HELD:
            begin
                held_next = '0;
            end
            CMD_REL_CHK:
            begin
                if (slot_rd.id == item_reg.id)
                begin
                    slot_we = 1'b1;
                    slot_waddr = idx_reg[SW-1:0];
                    slot_wr = slot_rd;
                    slot_wr.ref_m = 1'b0;
                end
                idx_next = idx_reg + CW'(1);
            end
            CMD_TWO_SEL:
            begin
                if ($signed(o0_reg.order) > $signed(slot_rd.order))
                begin
                    best_next = slot_rd;
                    best_idx_next = SW'(1);
                end
                else
                begin
                    best_next = o0_reg;
                    best_idx_next = '0;
                end
            end
            CMD_TWO_EMIT:
            begin
                q_we = 1'b1;
                q_wr = '{order: best_reg.order, id: best_reg.id};
                wp_next = wp_reg + QW'(1);
                slot_we = 1'b1;
                slot_waddr = best_idx_reg;
                slot_wr = best_reg;
                slot_wr.out_m = 1'b1;
            end
            CMD_STORE_SEL:
            begin
                slot_we = 1'b1;
                slot_waddr = best_idx_reg;
                slot_wr = item_reg;
            end
            CMD_OUT_EMIT:
            begin
                out_valid_next = 1'b1;
                ev_next = EV_EMIT;
                oq_next = q_rd;
                ost_next = ST_OK;
                ofill_next = held_reg;
                rp_next = rp_reg + QW'(1);
            end
            CMD_OUT_DONE:
            begin
                out_valid_next = 1'b1;
                ev_next = EV_DONE;
                oq_next = '0;
                ost_next = st_reg;
                ofill_next = held_reg;
            end
            default:
            begin
                slot_raddr = idx_reg[SW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            held_reg <= '0;
            idx_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
            found_reg <= 1'b0;
            older_reg <= 1'b0;
            st_reg <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg <= cap_next;
            held_reg <= held_next;
            idx_reg <= idx_next;
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            found_reg <= found_next;
            older_reg <= older_next;
            st_reg <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        item_reg <= item_next;
        skip_reg <= skip_next;
        o0_reg <= o0_next;
        best_reg <= best_next;
        best_idx_reg <= best_idx_next;
        mv_dst_reg <= mv_dst_next;
        ev_reg <= ev_next;
        oq_reg <= oq_next;
        ost_reg <= ost_next;
        ofill_reg <= ofill_next;
    end

    assign out_valid = out_valid_reg;
    assign out_ev = ev_reg;
    assign out_id = oq_reg.id;
    assign out_order = oq_reg.order;
    assign out_status = ost_reg;
    assign out_fill = ofill_reg;
    assign out_last = ev_reg;
endmodule
`default_nettype wire

FILE: tb/tb_decoded_picture_buffer_bump.sv
// Self-checking testbench for the decoded picture buffer bumping block.
`timescale 1ns / 100ps
`default_nettype none
module tb_decoded_picture_buffer_bump;
    import dpb_pkg::*;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic        ev;
        logic [15:0] id;
        logic [31:0] ord;
        logic        st;
        logic [4:0]  fill;
        logic        last;
    } dpb_res_t;

    typedef struct {
        bit          is_cfg;
        logic [4:0]  cfg;
        logic [1:0]  kind;
        logic [15:0] id;
        logic [31:0] ord;
        bit          r;
        bit          s;
        bit          o;
        bit          typed;
        logic        st;
        logic [4:0]  fill;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // shadow of the picture store
    logic [15:0]        pic_id_q [SLOTS];
    logic signed [31:0] pic_ord_q [SLOTS];
    bit                 pic_out_q [SLOTS];
    bit                 pic_ref_q [SLOTS];
    int                 held;
    logic [4:0]         capacity;

    dpb_res_t step_q[$];
    dpb_res_t display_q[$];

    int mismatches;
    int idle_cycles;
    int src_idle_pct;
    int snk_stall_pct;

    decoded_picture_buffer_bump u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int eff_cap();
        if (capacity == 0)
            return 1;
        if (capacity > SLOTS)
            return SLOTS;
        return int'(capacity);
    endfunction

    task automatic note_pic(logic ev, logic [15:0] id, logic [31:0] ord, logic st);
        dpb_res_t r;
        r.ev = ev;
        r.id = id;
        r.ord = ord;
        r.st = st;
        r.fill = '0;
        r.last = ev;
        step_q.push_back(r);
    endtask

    task automatic drop_slot(int idx);
        held--;
        if (idx != held)
        begin
            pic_id_q[idx] = pic_id_q[held];
            pic_ord_q[idx] = pic_ord_q[held];
            pic_out_q[idx] = pic_out_q[held];
            pic_ref_q[idx] = pic_ref_q[held];
        end
    endtask

    task automatic bump_one(output bit found);
        int best;
        best = -1;
        for (int i = 0; i < held; i++)
            if (!pic_out_q[i] && (best < 0 || pic_ord_q[i] < pic_ord_q[best]))
                best = i;
        found = (best >= 0);
        if (found)
        begin
            note_pic(EV_EMIT, pic_id_q[best], pic_ord_q[best], ST_OK);
            pic_out_q[best] = 1'b1;
            if (!pic_ref_q[best])
                drop_slot(best);
        end
    endtask

    task automatic add_generic(logic [15:0] id, logic signed [31:0] ord, bit r, bit s,
                               bit o, output logic st);
        int  i;
        bit  found;
        bit  older;
        i = 0;
        st = ST_OK;
        while (i < held)
            if (pic_out_q[i] && !pic_ref_q[i])
                drop_slot(i);
            else
                i++;
        if (r)
        begin
            while (held >= eff_cap())
            begin
                bump_one(found);
                if (!found)
                begin
                    st = ST_FULL;
                    return;
                end
            end
        end
        else
        begin
            if (s)
                return;
            while (held >= eff_cap())
            begin
                older = 1'b0;
                if (!o)
                    for (int k = 0; k < held; k++)
                        if (pic_ord_q[k] < ord)
                            older = 1'b1;
                if (!older)
                begin
                    note_pic(EV_EMIT, id, ord, ST_OK);
                    return;
                end
                bump_one(found);
                if (!found)
                begin
                    st = ST_FULL;
                    return;
                end
            end
        end
        pic_id_q[held] = id;
        pic_ord_q[held] = ord;
        pic_out_q[held] = o;
        pic_ref_q[held] = r;
        held++;
    endtask

    task automatic add_two_ref(logic [15:0] id, logic signed [31:0] ord, bit r, bit o);
        int idx;
        idx = -1;
        if (held >= TWO_REF_CAP)
        begin
            idx = (pic_ord_q[0] > pic_ord_q[1]) ? 1 : 0;
            if (!pic_out_q[idx])
            begin
                note_pic(EV_EMIT, pic_id_q[idx], pic_ord_q[idx], ST_OK);
                pic_out_q[idx] = 1'b1;
            end
        end
        if (!r)
        begin
            note_pic(EV_EMIT, id, ord, ST_OK);
            return;
        end
        if (idx < 0)
        begin
            idx = held;
            held++;
        end
        pic_id_q[idx] = id;
        pic_ord_q[idx] = ord;
        pic_out_q[idx] = o;
        pic_ref_q[idx] = 1'b1;
    endtask

    // Works out the results of one command into step_q, fill count applied.
    task automatic predict_display(logic [1:0] kind, logic [15:0] id, logic [31:0] ord,
                                   bit r, bit s, bit o);
        logic st;
        bit   found;
        st = ST_OK;
        step_q.delete();
        case (kind)
            KIND_ADD:
                if (eff_cap() == TWO_REF_CAP)
                    add_two_ref(id, ord, r, o);
                else
                    add_generic(id, ord, r, s, o, st);
            KIND_FLUSH:
            begin
                found = 1'b1;
                while (found)
                    bump_one(found);
                held = 0;
            end
            KIND_RELEASE:
                for (int i = 0; i < held; i++)
                    if (pic_id_q[i] == id)
                        pic_ref_q[i] = 1'b0;
            default: ;
        endcase
        note_pic(EV_DONE, '0, '0, st);
        foreach (step_q[k])
            step_q[k].fill = 5'(held);
    endtask

    always @(posedge clk)
        if (rst_n)
            m_tready <= ($urandom_range(99) >= snk_stall_pct);

    // output monitor and watchdog
    always @(posedge clk)
    begin
        dpb_res_t want;
        dpb_res_t got;
        if (rst_n)
        begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                got.ev = m_tuser;
                got.id = m_tdata[15:0];
                got.ord = m_tdata[47:16];
                got.st = m_tdata[48];
                got.fill = m_tdata[53:49];
                got.last = m_tlast;
                if (display_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction ev=%0d id=%h ord=%h",
                                 got.ev, got.id, got.ord);
                end
                else
                begin
                    want = display_q.pop_front();
                    if (got.ev !== want.ev || got.id !== want.id || got.ord !== want.ord ||
                        got.st !== want.st || got.fill !== want.fill ||
                        got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp ev=%0d id=%h ord=%h st=%0d fill=%0d last=%0d act ev=%0d id=%h ord=%h st=%0d fill=%0d last=%0d",
                                     want.ev, want.id, want.ord, want.st, want.fill,
                                     want.last, got.ev, got.id, got.ord, got.st,
                                     got.fill, got.last);
                    end
                end
            end
        end
    end

    task automatic send_cmd(logic [1:0] kind, logic [15:0] id, logic [31:0] ord,
                            bit r, bit s, bit o);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'b0, o, s, r, ord, id};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (display_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [4:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        capacity = v;
        @(posedge clk);
    endtask

    task automatic run_cmd(logic [1:0] kind, logic [15:0] id, logic [31:0] ord,
                           bit r, bit s, bit o);
        send_cmd(kind, id, ord, r, s, o);
        predict_display(kind, id, ord, r, s, o);
        foreach (step_q[k])
            display_q.push_back(step_q[k]);
    endtask

    dir_row_t dir_rows[] = '{
        '{0, 0, KIND_FLUSH, 16'h0000, 32'h0, 0, 0, 0, 1, ST_OK, 5'd0},
        '{0, 0, KIND_RELEASE, 16'h1234, 32'h0, 0, 0, 0, 1, ST_OK, 5'd0},
        '{0, 0, 2'd3, 16'hFFFF, 32'hFFFFFFFF, 1, 1, 1, 1, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'hFFFF, 32'h7FFFFFFF, 1, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0000, 32'h80000000, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0005, 32'h00000003, 0, 1, 0, 1, ST_OK, 5'd2},
        '{0, 0, KIND_ADD, 16'h0006, 32'h00000000, 0, 0, 1, 0, ST_OK, 5'd0},
        '{0, 0, KIND_RELEASE, 16'hFFFF, 32'h0, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_FLUSH, 16'h0, 32'h0, 0, 0, 0, 0, ST_OK, 5'd0},
        '{1, 5'd1, KIND_ADD, 16'h0, 32'h0, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h000A, 32'h00000001, 1, 0, 1, 1, ST_OK, 5'd1},
        '{0, 0, KIND_ADD, 16'h000B, 32'h00000002, 1, 0, 0, 1, ST_FULL, 5'd1},
        '{0, 0, KIND_ADD, 16'h000C, 32'hFFFFFFFB, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_RELEASE, 16'h000A, 32'h0, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h000D, 32'h00000004, 1, 0, 0, 0, ST_OK, 5'd0},
        '{1, 5'd2, KIND_ADD, 16'h0, 32'h0, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0014, 32'h00000005, 1, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0015, 32'h00000003, 1, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0016, 32'h00000009, 1, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0017, 32'h00000001, 0, 1, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0018, 32'h00000003, 1, 0, 1, 0, ST_OK, 5'd0},
        '{1, 5'd31, KIND_ADD, 16'h0, 32'h0, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0020, 32'h00000010, 1, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0021, 32'h00000008, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0022, 32'h0000000C, 1, 0, 0, 0, ST_OK, 5'd0},
        '{1, 5'd3, KIND_ADD, 16'h0, 32'h0, 0, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0023, 32'h00000002, 1, 0, 0, 0, ST_OK, 5'd0},
        '{0, 0, KIND_ADD, 16'h0024, 32'h00000001, 0, 0, 0, 0, ST_OK, 5'd0}
    };

    logic [4:0] phase_caps [8] = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd3, 5'd2, 5'd4};

    initial
    begin
        logic [1:0]  kind;
        logic [15:0] id;
        logic [31:0] ord;
        bit          r;
        bit          s;
        bit          o;
        int          pick;
        dpb_res_t    done;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        held = 0;
        capacity = CAP_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[n])
        begin
            if (dir_rows[n].is_cfg)
                write_capacity(dir_rows[n].cfg);
            else if (dir_rows[n].typed)
            begin
                send_cmd(dir_rows[n].kind, dir_rows[n].id, dir_rows[n].ord,
                         dir_rows[n].r, dir_rows[n].s, dir_rows[n].o);
                predict_display(dir_rows[n].kind, dir_rows[n].id, dir_rows[n].ord,
                                dir_rows[n].r, dir_rows[n].s, dir_rows[n].o);
                done.ev = EV_DONE;
                done.id = '0;
                done.ord = '0;
                done.st = dir_rows[n].st;
                done.fill = dir_rows[n].fill;
                done.last = 1'b1;
                display_q.push_back(done);
            end
            else
                run_cmd(dir_rows[n].kind, dir_rows[n].id, dir_rows[n].ord,
                        dir_rows[n].r, dir_rows[n].s, dir_rows[n].o);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            write_capacity(ph == 7 ? 5'($urandom_range(0, 31)) : phase_caps[ph]);
            src_idle_pct = (ph % 4 == 1) ? 53 : (ph % 4 == 3) ? 38 : 0;
            snk_stall_pct = (ph % 4 == 2) ? 53 : (ph % 4 == 3) ? 38 : 0;
            for (int n = 0; n < 11; n++)
            begin
                // hold off until the block has delivered everything
                if (ph == 1 && n == 7)
                    wait_drained();
                pick = $urandom_range(99);
                kind = (pick < 72) ? KIND_ADD : (pick < 88) ? KIND_RELEASE :
                       (pick < 97) ? KIND_FLUSH : 2'd3;
                id = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
                if (kind == KIND_RELEASE && held > 0 && $urandom_range(9) < 7)
                    id = pic_id_q[$urandom_range(0, held - 1)];
                ord = ($urandom_range(9) < 7) ? 32'($urandom_range(0, 200)) - 32'd100
                                              : 32'($urandom);
                r = ($urandom_range(9) < 6);
                s = ($urandom_range(3) == 0);
                o = ($urandom_range(4) == 0);
                run_cmd(kind, id, ord, r, s, o);
            end
        end

        wait_drained();
        if (mismatches == 0 && display_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/dpb_pkg.sv
hw/rtl/dpb_ram.sv
hw/rtl/dpb_ctrl.sv
hw/rtl/dpb_datapath.sv
hw/rtl/decoded_picture_buffer_bump.sv
tb/tb_decoded_picture_buffer_bump.sv
